FILE: design/grid_avalanche_diffusion_step_defines.svh
// Assertion macros shared by the block's modules.
`ifndef GRID_AVALANCHE_DIFFUSION_STEP_DEFINES_SVH
`define GRID_AVALANCHE_DIFFUSION_STEP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent (or after a leading delay).
`define GADS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> cons) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GADS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/gads_pkg.sv
package gads_pkg;

  localparam int EDGE_MAX_DEF = 16;

  localparam logic [15:0] VALUE_CAP = 16'hFF00;
  localparam logic [12:0] COUNT_CAP = 13'h1FFF;
  localparam logic [31:0] NOISE_KEY = 32'h9E3779B9;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_WR,
    CMD_RD,
    CMD_RUN_INIT,
    CMD_STEP_BEGIN,
    CMD_P1_RD,
    CMD_P1_WR,
    CMD_P2_RD,
    CMD_P2_WR,
    CMD_STEP_END
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   code;
    logic [2:0]  nbr;
    logic        load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic steps_done;
    logic n_small;
    logic last_cell;
  } dp_status_t;

  // 32-bit xorshift of the cell index mixed with the step key, low five bits.
  function automatic logic [4:0] noise5(input logic [31:0] idx, input logic [31:0] key);
    logic [31:0] x;
    x = idx ^ key;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x[4:0];
  endfunction

endpackage

FILE: design/gads_ctrl.sv
`include "grid_avalanche_diffusion_step_defines.svh"

module gads_ctrl
  import gads_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR,
    S_RD,
    S_RUN_INIT,
    S_STEP_CHK,
    S_P1_RD,
    S_P1_WR,
    S_P2_RD,
    S_P2_WR,
    S_STEP_END,
    S_DONE
  } state_t;

  state_t     state;
  logic [2:0] k;
  logic       load;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign load = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      k     <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (status.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (load) begin
            case (op)
              OP_WRITE: state <= S_WR;
              OP_READ:  state <= S_RD;
              OP_RUN:   state <= S_RUN_INIT;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_WR:       state <= S_DONE;
        S_RD:       state <= S_DONE;
        S_RUN_INIT: state <= S_STEP_CHK;
        S_STEP_CHK: begin
          if (status.steps_done) state <= S_DONE;
          else if (status.n_small) state <= S_STEP_END;
          else state <= S_P1_RD;
        end
        S_P1_RD: state <= S_P1_WR;
        S_P1_WR: begin
          k <= '0;
          state <= status.last_cell ? S_P2_RD : S_P1_RD;
        end
        S_P2_RD: begin
          if (k == 3'd5) begin
            k <= '0;
            state <= S_P2_WR;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_P2_WR: begin
          k <= '0;
          state <= status.last_cell ? S_STEP_END : S_P2_RD;
        end
        S_STEP_END: state <= S_STEP_CHK;
        S_DONE:     state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.nbr  = k;
    cmd.load = load;
    case (state)
      S_CLEAR:    cmd.code = CMD_CLR;
      S_WR:       cmd.code = CMD_WR;
      S_RD:       cmd.code = CMD_RD;
      S_RUN_INIT: cmd.code = CMD_RUN_INIT;
      S_STEP_CHK: cmd.code = CMD_STEP_BEGIN;
      S_P1_RD:    cmd.code = CMD_P1_RD;
      S_P1_WR:    cmd.code = CMD_P1_WR;
      S_P2_RD:    cmd.code = CMD_P2_RD;
      S_P2_WR:    cmd.code = CMD_P2_WR;
      S_STEP_END: cmd.code = CMD_STEP_END;
      default:    cmd.code = CMD_NONE;
    endcase
  end

  `GADS_ASSERT_IMPL(a_rdwr_latency, clk, rst, load && (op == OP_WRITE || op == OP_READ), ##2 done, "read or write item did not finish in two cycles")
  `GADS_ASSERT_NEXT(a_done_then_idle, clk, rst, done, !busy, "controller not idle after a result")
  `GADS_ASSERT_NEXT(a_nbr_sweep, clk, rst, state == S_P2_WR, k == 3'd0, "neighbor counter not rewound after a cell")

endmodule

FILE: design/gads_dp.sv
`include "grid_avalanche_diffusion_step_defines.svh"

module gads_dp
  import gads_pkg::*;
#(
  parameter int EDGE_MAX = EDGE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic [1:0]  op,
  input  logic [11:0] cell_index,
  input  logic [15:0] cell_value,
  input  logic [15:0] step_count,
  input  logic [4:0]  grid_edge,
  input  logic [7:0]  threshold_integer,
  output logic [15:0] read_value,
  output logic [12:0] avalanche_count
);

  localparam int CELLS = EDGE_MAX * EDGE_MAX * EDGE_MAX;
  localparam int AW    = $clog2(CELLS);
  localparam int EW    = $clog2(EDGE_MAX + 1);

  // Value memory word: value in [17:2], residual in [1:0].
  logic [17:0] vmem [CELLS];
  logic [8:0]  fmem [CELLS];

  logic [17:0]   vmem_rdata, vmem_wd;
  logic [AW-1:0] vmem_ra, vmem_wa;
  logic          vmem_re, vmem_we;
  logic [8:0]    flow_rdata, fmem_wd;
  logic [AW-1:0] fmem_ra, fmem_wa;
  logic          fmem_re, fmem_we;

  logic [1:0]    op_q;
  logic          idx_ok_q;
  logic [AW-1:0] addr_q;
  logic [15:0]   val_q;
  logic [15:0]   steps_q;

  logic [AW-1:0] clr_addr;
  logic [EW-1:0] n, x, y, z;
  logic [2*EW-1:0] nn;
  logic [EW-1:0] nm2;
  logic [AW-1:0] idx;
  logic [15:0]   step_cnt;
  logic [31:0]   key;
  logic [12:0]   count;
  logic [12:0]   last_av;
  logic [11:0]   acc, acc_total;

  logic [15:0]   v;
  logic [1:0]    res;
  logic [15:0]   f, v_leak, p1_val, p2_val;
  logic [4:0]    noise;
  logic signed [18:0] p1_sum;
  logic [16:0]   p2_sum;
  logic          aval;
  logic [AW-1:0] nbr_addr, start_idx;

  assign nn        = n * n;
  assign nm2       = n - EW'(2);
  assign start_idx = AW'(nn) + AW'(n) + AW'(1);

  assign status.clr_last   = (clr_addr == AW'(CELLS - 1));
  assign status.steps_done = (step_cnt == steps_q);
  assign status.n_small    = (n < EW'(3));
  assign status.last_cell  = (x == nm2) && (y == nm2) && (z == nm2);

  assign read_value      = (op_q == OP_READ && idx_ok_q) ? vmem_rdata[17:2] : 16'd0;
  assign avalanche_count = last_av;

  // First phase arithmetic.
  assign v      = vmem_rdata[17:2];
  assign res    = vmem_rdata[1:0];
  assign aval   = (v[15:8] > threshold_integer);
  assign f      = v + {14'd0, res};
  assign noise  = noise5(32'(idx), key);
  assign v_leak = {3'd0, v[15:3]} * 16'd6;
  assign p1_sum = $signed({3'd0, f}) - $signed({5'd0, f[15:2]})
                + $signed({14'd0, noise}) - $signed({3'd0, v_leak});
  assign p1_val = p1_sum[18] ? 16'd0
                : (p1_sum > $signed({3'd0, VALUE_CAP})) ? VALUE_CAP : p1_sum[15:0];

  // Second phase: the last neighbor flow arrives in the write cycle.
  assign acc_total = acc + {3'd0, flow_rdata};
  assign p2_sum    = {1'b0, v} + {5'd0, acc_total};
  assign p2_val    = (p2_sum > {1'b0, VALUE_CAP}) ? VALUE_CAP : p2_sum[15:0];

  always_comb begin
    case (cmd.nbr)
      3'd0:    nbr_addr = idx + AW'(1);
      3'd1:    nbr_addr = idx - AW'(1);
      3'd2:    nbr_addr = idx + AW'(n);
      3'd3:    nbr_addr = idx - AW'(n);
      3'd4:    nbr_addr = idx + AW'(nn);
      default: nbr_addr = idx - AW'(nn);
    endcase
  end

  always_comb begin
    vmem_re = 1'b0;
    vmem_ra = idx;
    vmem_we = 1'b0;
    vmem_wa = idx;
    vmem_wd = {p1_val, f[1:0]};
    fmem_re = 1'b0;
    fmem_ra = nbr_addr;
    fmem_we = 1'b0;
    fmem_wa = idx;
    fmem_wd = aval ? v[15:7] : 9'd0;
    case (cmd.code)
      CMD_CLR: begin
        vmem_we = 1'b1;
        vmem_wa = clr_addr;
        vmem_wd = '0;
        fmem_we = 1'b1;
        fmem_wa = clr_addr;
        fmem_wd = '0;
      end
      CMD_WR: begin
        vmem_we = idx_ok_q;
        vmem_wa = addr_q;
        vmem_wd = {val_q, 2'd0};
      end
      CMD_RD: begin
        vmem_re = idx_ok_q;
        vmem_ra = addr_q;
      end
      CMD_P1_RD: vmem_re = 1'b1;
      CMD_P1_WR: begin
        vmem_we = aval;
        fmem_we = 1'b1;
      end
      CMD_P2_RD: begin
        vmem_re = (cmd.nbr == 3'd0);
        fmem_re = 1'b1;
      end
      CMD_P2_WR: begin
        vmem_we = (acc_total != 12'd0);
        vmem_wd = {p2_val, res};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vmem_re) vmem_rdata <= vmem[vmem_ra];
    if (vmem_we) vmem[vmem_wa] <= vmem_wd;
    if (fmem_re) flow_rdata <= fmem[fmem_ra];
    if (fmem_we) fmem[fmem_wa] <= fmem_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      op_q     <= OP_WRITE;
      idx_ok_q <= 1'b0;
      last_av  <= '0;
      n        <= EW'(EDGE_MAX);
      step_cnt <= '0;
      steps_q  <= '0;
    end else begin
      if (cmd.load) begin
        op_q     <= op;
        idx_ok_q <= (32'(cell_index) < 32'(CELLS));
        addr_q   <= AW'(cell_index);
        val_q    <= cell_value;
        steps_q  <= step_count;
      end
      case (cmd.code)
        CMD_CLR: clr_addr <= clr_addr + AW'(1);
        CMD_RUN_INIT: begin
          n        <= (32'(grid_edge) > 32'(EDGE_MAX)) ? EW'(EDGE_MAX) : EW'(grid_edge);
          step_cnt <= '0;
          key      <= '0;
        end
        CMD_STEP_BEGIN: begin
          x     <= EW'(1);
          y     <= EW'(1);
          z     <= EW'(1);
          idx   <= start_idx;
          count <= '0;
        end
        CMD_P1_WR, CMD_P2_WR: begin
          if (cmd.code == CMD_P1_WR && aval && count != COUNT_CAP) count <= count + 13'd1;
          // Walk the interior in raster order; wrap to the first cell after the last.
          if (x != nm2) begin
            x   <= x + EW'(1);
            idx <= idx + AW'(1);
          end else if (y != nm2) begin
            x   <= EW'(1);
            y   <= y + EW'(1);
            idx <= idx + AW'(3);
          end else if (z != nm2) begin
            x   <= EW'(1);
            y   <= EW'(1);
            z   <= z + EW'(1);
            idx <= idx + AW'({n, 1'b0}) + AW'(3);
          end else begin
            x   <= EW'(1);
            y   <= EW'(1);
            z   <= EW'(1);
            idx <= start_idx;
          end
        end
        CMD_P2_RD: acc <= (cmd.nbr == 3'd0) ? 12'd0 : acc_total;
        CMD_STEP_END: begin
          last_av  <= status.n_small ? 13'd0 : count;
          step_cnt <= step_cnt + 16'd1;
          key      <= key + NOISE_KEY;
        end
        default: ;
      endcase
    end
  end

  `GADS_ASSERT_NEXT(a_count_hold, clk, rst, cmd.code != CMD_STEP_END, $stable(last_av), "avalanche count changed outside a step end")

endmodule

FILE: design/grid_avalanche_diffusion_step.sv
// Cubic avalanche/diffusion grid. After reset the block clears its EDGE_MAX^3 cell
// memories, one cell a cycle, with busy high; registers can be written meanwhile. An
// item is taken when start is high and busy low; its single result shows on read_value
// and avalanche_count for the one cycle that done is high, and must be taken then, since
// the block cannot be held off. A write or read passes through its access state before
// done; op 3 goes straight to done. Each of the S steps of a run on an edge n walks the
// interior cells twice: the first phase reads and writes each cell, and the second reads
// the flow memory, which has one read port, once for each of the six neighbors before
// writing the cell; when n is below three a step does no cell work.
module grid_avalanche_diffusion_step
  import gads_pkg::*;
#(
  parameter int EDGE_MAX = EDGE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [11:0] cell_index,
  input  logic [15:0] cell_value,
  input  logic [15:0] step_count,
  output logic        done,
  output logic [15:0] read_value,
  output logic [12:0] avalanche_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] grid_edge;
  logic [7:0] threshold_integer;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, threshold_integer} : {27'd0, grid_edge};

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_edge         <= 5'd16;
      threshold_integer <= 8'd120;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) threshold_integer <= pwdata[7:0];
      else grid_edge <= pwdata[4:0];
    end
  end

  gads_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  gads_dp #(
    .EDGE_MAX (EDGE_MAX)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .op                (op),
    .cell_index        (cell_index),
    .cell_value        (cell_value),
    .step_count        (step_count),
    .grid_edge         (grid_edge),
    .threshold_integer (threshold_integer),
    .read_value        (read_value),
    .avalanche_count   (avalanche_count)
  );

endmodule
